FILE: src/ifsfern_pkg.sv
// Package for the fern point generator: beat types, register indexes,
// map codes and fixed-point helpers.
// No dependencies.
package ifsfern_pkg;

    localparam int POINT_W = 24;
    localparam int PIXEL_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam int SCALE_W = 12;
    localparam int XOFF_W = 10;
    localparam int YOFF_W = 15;

    localparam logic [SCALE_W-1:0] SCALE_RST = 12'd0;
    localparam logic [XOFF_W-1:0] XOFF_RST = 10'd500;
    localparam logic [YOFF_W-1:0] YOFF_RST = 15'd10;

    localparam longint POINT_MAX = 64'sd8388607;
    localparam longint POINT_MIN = -64'sd8388608;

    // Register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YOFF = 2'd2;

    // Step opcodes
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Draw thresholds of the standard split
    localparam logic [6:0] DRAW_LEFT = 7'd85;
    localparam logic [6:0] DRAW_RIGHT = 7'd92;
    localparam logic [6:0] DRAW_STEM = 7'd99;

    typedef enum logic [1:0] {
        MAP_LEAFLET = 2'd0,
        MAP_LEFT = 2'd1,
        MAP_RIGHT = 2'd2,
        MAP_STEM = 2'd3
    } map_sel_t;

    typedef struct packed {
        logic       op;
        logic [6:0] draw;
    } step_item_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [PIXEL_W-1:0]        pixel_x;
        logic [PIXEL_W-1:0]        pixel_y;
        logic                      visible;
    } res_item_t;

    // Hundredths to fixed point, rounded half away from zero
    function automatic longint coef_q(input int pct, input int fb);
        longint mag;
        mag = ((longint'(pct < 0 ? -pct : pct) << fb) + 64'sd50) / 100;
        return (pct < 0) ? -mag : mag;
    endfunction

endpackage

FILE: src/ifs_fern_point_generator_unit.sv
// Top level of the fern point generator: input stage, affine map update,
// screen projection and result register. Depends on ifsfern_pkg.
//
// Channel   Dir  Handshake               Beat
// step      in   step_valid/step_stall   ifsfern_pkg::step_item_t (op, draw)
// res       out  res_valid/res_stall     ifsfern_pkg::res_item_t
// cfg       in   cfg_we                  cfg_index, cfg_data (no read-back)
//
// One beat per cycle sustained while res_stall is low. A step beat is taken
// into the input register and moves into the result register once that is
// free or being emptied, and res_valid then rises with it.
// The point update and the projection share one pass of logic between the
// input register and the result register: four constant-coefficient
// multiplies for the map and two scale multiplies for the projection.
// Reset loads the start point (10,10) and the register defaults.
// A stall on res holds the result register; the input register then fills
// and step_stall rises in the same cycle, so no beat is lost.
module ifs_fern_point_generator_unit #(
    parameter int FRAC_BITS = 16,
    parameter int SCREEN_W = 1024,
    parameter int SCREEN_H = 768
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step_valid,
    output logic                                   step_stall,
    input  ifsfern_pkg::step_item_t                step_data,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output ifsfern_pkg::res_item_t                 res_data,
    input  logic                                   cfg_we,
    input  logic [ifsfern_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ifsfern_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ifsfern_pkg::*;

    // Coefficient width holds the largest constant term (1.6) plus sign
    localparam int CW = FRAC_BITS + 2;
    localparam int PW = POINT_W + CW;
    localparam int SW = PW + 1;
    // Projection: 13-bit signed scale times the point, plus an offset
    localparam int PJW = POINT_W + SCALE_W + 1;
    localparam int PXW = PJW + 1;

    localparam logic signed [SW-1:0] HALF_Q = SW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'(POINT_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(POINT_MIN);
    localparam logic signed [PXW-1:0] SCR_W = PXW'(SCREEN_W);
    localparam logic signed [PXW-1:0] SCR_H = PXW'(SCREEN_H);

    // Start point 10.0, pinned to the top of the range at large FRAC_BITS
    localparam longint START_RAW = longint'(10) << FRAC_BITS;
    localparam logic signed [POINT_W-1:0] START_Q =
        (START_RAW > POINT_MAX) ? POINT_W'(POINT_MAX) : POINT_W'(START_RAW);

    // Map coefficients (x' = a*x + b*y, y' = c*x + d*y + f; e is zero)
    localparam logic signed [CW-1:0] A_LEAF = CW'(coef_q(85, FRAC_BITS));
    localparam logic signed [CW-1:0] B_LEAF = CW'(coef_q(4, FRAC_BITS));
    localparam logic signed [CW-1:0] C_LEAF = CW'(coef_q(-4, FRAC_BITS));
    localparam logic signed [CW-1:0] D_LEAF = CW'(coef_q(85, FRAC_BITS));
    localparam logic signed [CW-1:0] F_LEAF = CW'(coef_q(160, FRAC_BITS));
    localparam logic signed [CW-1:0] A_LEFT = CW'(coef_q(-15, FRAC_BITS));
    localparam logic signed [CW-1:0] B_LEFT = CW'(coef_q(28, FRAC_BITS));
    localparam logic signed [CW-1:0] C_LEFT = CW'(coef_q(26, FRAC_BITS));
    localparam logic signed [CW-1:0] D_LEFT = CW'(coef_q(24, FRAC_BITS));
    localparam logic signed [CW-1:0] F_LEFT = CW'(coef_q(44, FRAC_BITS));
    localparam logic signed [CW-1:0] A_RIGHT = CW'(coef_q(20, FRAC_BITS));
    localparam logic signed [CW-1:0] B_RIGHT = CW'(coef_q(-26, FRAC_BITS));
    localparam logic signed [CW-1:0] C_RIGHT = CW'(coef_q(23, FRAC_BITS));
    localparam logic signed [CW-1:0] D_RIGHT = CW'(coef_q(22, FRAC_BITS));
    localparam logic signed [CW-1:0] F_RIGHT = CW'(coef_q(160, FRAC_BITS));
    localparam logic signed [CW-1:0] D_STEM = CW'(coef_q(16, FRAC_BITS));

    // Configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [XOFF_W-1:0]  x_offset_reg;
    logic [YOFF_W-1:0]  y_offset_reg;

    // Input stage and point state
    logic                       a_valid_reg, a_valid_next;
    step_item_t                 a_item_reg;
    logic signed [POINT_W-1:0]  cur_x_reg, cur_x_next;
    logic signed [POINT_W-1:0]  cur_y_reg, cur_y_next;

    // Result stage
    logic       res_valid_reg, res_valid_next;
    res_item_t  res_item_reg, res_item_next;

    logic       step_take;
    logic       a_move;
    map_sel_t   map_sel;

    logic signed [CW-1:0]       coef_a, coef_b, coef_c, coef_d, coef_f;
    logic signed [PW-1:0]       prod_ax, prod_by, prod_cx, prod_dy;
    logic signed [SW-1:0]       acc_x, acc_y, new_x, new_y;
    logic signed [POINT_W-1:0]  eff_x, eff_y;
    logic signed [PJW-1:0]      proj_x, proj_y;
    logic signed [PXW-1:0]      pix_x, pix_y;
    logic                       pix_vis;

    // ---------------------------------------------------------------
    // Handshake: advance the input stage whenever the result register
    // is free or being emptied this cycle.
    // ---------------------------------------------------------------
    assign a_move = a_valid_reg && (!res_valid_reg || !res_stall);
    assign step_stall = a_valid_reg && !a_move;
    assign step_take = step_valid && !step_stall;

    always_comb
    begin
        if (step_take)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_comb
    begin
        if (a_move)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // ---------------------------------------------------------------
    // Map choice from the draw; ninety-nine and above is the stem.
    // ---------------------------------------------------------------
    always_comb
    begin
        if (a_item_reg.draw < DRAW_LEFT)
            map_sel = MAP_LEAFLET;
        else if (a_item_reg.draw < DRAW_RIGHT)
            map_sel = MAP_LEFT;
        else if (a_item_reg.draw < DRAW_STEM)
            map_sel = MAP_RIGHT;
        else
            map_sel = MAP_STEM;
    end

    always_comb
    begin
        case (map_sel)
            MAP_LEAFLET:
            begin
                coef_a = A_LEAF;  coef_b = B_LEAF;  coef_c = C_LEAF;
                coef_d = D_LEAF;  coef_f = F_LEAF;
            end
            MAP_LEFT:
            begin
                coef_a = A_LEFT;  coef_b = B_LEFT;  coef_c = C_LEFT;
                coef_d = D_LEFT;  coef_f = F_LEFT;
            end
            MAP_RIGHT:
            begin
                coef_a = A_RIGHT; coef_b = B_RIGHT; coef_c = C_RIGHT;
                coef_d = D_RIGHT; coef_f = F_RIGHT;
            end
            default:
            begin
                coef_a = '0;      coef_b = '0;      coef_c = '0;
                coef_d = D_STEM;  coef_f = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Affine update: full products, round half up, floor shift, add the
    // constant term, then clamp to the 24-bit range.
    // ---------------------------------------------------------------
    always_comb
    begin
        prod_ax = PW'(cur_x_reg) * PW'(coef_a);
        prod_by = PW'(cur_y_reg) * PW'(coef_b);
        prod_cx = PW'(cur_x_reg) * PW'(coef_c);
        prod_dy = PW'(cur_y_reg) * PW'(coef_d);
        acc_x = SW'(prod_ax) + SW'(prod_by) + HALF_Q;
        acc_y = SW'(prod_cx) + SW'(prod_dy) + HALF_Q;
        new_x = acc_x >>> FRAC_BITS;
        new_y = (acc_y >>> FRAC_BITS) + SW'(coef_f);
    end

    // Restart reports the start point itself; advance reports the old point
    assign eff_x = (a_item_reg.op == OP_RESTART) ? START_Q : cur_x_reg;
    assign eff_y = (a_item_reg.op == OP_RESTART) ? START_Q : cur_y_reg;

    always_comb
    begin
        if (a_item_reg.op == OP_RESTART)
        begin
            cur_x_next = START_Q;
            cur_y_next = START_Q;
        end
        else
        begin
            if (new_x > SAT_HI)
                cur_x_next = POINT_W'(POINT_MAX);
            else if (new_x < SAT_LO)
                cur_x_next = POINT_W'(POINT_MIN);
            else
                cur_x_next = new_x[POINT_W-1:0];
            if (new_y > SAT_HI)
                cur_y_next = POINT_W'(POINT_MAX);
            else if (new_y < SAT_LO)
                cur_y_next = POINT_W'(POINT_MIN);
            else
                cur_y_next = new_y[POINT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Projection: floor of scale*point, then offset; report only pixels
    // strictly inside the screen.
    // ---------------------------------------------------------------
    always_comb
    begin
        proj_x = (PJW'(signed'({1'b0, scale_reg})) * PJW'(eff_x)) >>> FRAC_BITS;
        proj_y = (PJW'(signed'({1'b0, scale_reg})) * PJW'(eff_y)) >>> FRAC_BITS;
        pix_x = PXW'(proj_x) + PXW'(signed'({1'b0, x_offset_reg}));
        pix_y = PXW'(proj_y) - PXW'(signed'({1'b0, y_offset_reg}));
        pix_vis = (pix_x > 0) && (pix_x < SCR_W) && (pix_y > 0) && (pix_y < SCR_H);

        res_item_next.point_x = eff_x;
        res_item_next.point_y = eff_y;
        res_item_next.visible = pix_vis;
        res_item_next.pixel_x = pix_vis ? pix_x[PIXEL_W-1:0] : '0;
        res_item_next.pixel_y = pix_vis ? pix_y[PIXEL_W-1:0] : '0;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_RST;
            x_offset_reg <= XOFF_RST;
            y_offset_reg <= YOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE: scale_reg    <= cfg_data[SCALE_W-1:0];
                CFG_XOFF:  x_offset_reg <= cfg_data[XOFF_W-1:0];
                CFG_YOFF:  y_offset_reg <= cfg_data[YOFF_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            cur_x_reg     <= START_Q;
            cur_y_reg     <= START_Q;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            res_valid_reg <= res_valid_next;
            if (a_move)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (step_take)
            a_item_reg <= step_data;
        if (a_move)
            res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data = res_item_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        step_stall |-> (a_valid_reg && res_valid_reg && res_stall))
        else $error("step stalled while the pipeline could drain");

    a_restart_loads_start: assert property (@(posedge clk) disable iff (!rst_n)
        (a_move && a_item_reg.op == OP_RESTART) |=>
            (cur_x_reg == START_Q && cur_y_reg == START_Q
             && res_data.point_x == START_Q && res_data.point_y == START_Q))
        else $error("restart beat did not reload the start point");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !a_move |=> ($stable(cur_x_reg) && $stable(cur_y_reg)))
        else $error("point moved without a beat passing the input stage");

    a_hidden_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.visible) |-> (res_data.pixel_x == '0 && res_data.pixel_y == '0))
        else $error("pixel reported for an invisible point");

endmodule
